>>> rtl/lkt_pkg.sv
package lkt_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_WIDTH  = $clog2(DEPTH);
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_SHIFT  = 4'b1000
    } state_t;

endpackage

>>> rtl/lkt_ram.sv
module lkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/linear_keyed_table.sv
// Keyed table with linear search in insertion order. Assert start with cmd, key and value
// while busy is low; the item is taken at that edge and busy rises. One result comes back
// per item on status, found_value and entries, valid for the single cycle in which done is
// high; it must be captured then. Key and value stores sit in single-port-read RAMs and are
// scanned one entry per cycle. Add and find end once the scan hits the key or passes the last
// entry. A delete that finds its key takes the same time wherever the key sits, since the
// entries behind it are moved down one per cycle. busy drops in the cycle that done is high,
// so a new item may start right then.
module linear_keyed_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic [lkt_pkg::KEY_WIDTH-1:0]    key,
    input  logic [lkt_pkg::VALUE_WIDTH-1:0]  value,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [lkt_pkg::VALUE_WIDTH-1:0]  found_value,
    output logic [lkt_pkg::COUNT_WIDTH-1:0]  entries
);
    import lkt_pkg::*;

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] idx_reg, idx_next;
    logic [ADDR_WIDTH-1:0]  ptr_reg, ptr_next;
    logic                   vld_reg, vld_next;
    logic                   found_reg, found_next;
    logic [VALUE_WIDTH-1:0] fv_reg, fv_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;

    logic                   done_reg, done_next;
    logic [1:0]             status_reg, status_next;
    logic [VALUE_WIDTH-1:0] out_fv_reg, out_fv_next;
    logic [COUNT_WIDTH-1:0] entries_reg, entries_next;

    logic                   we;
    logic [ADDR_WIDTH-1:0]  waddr;
    logic [ADDR_WIDTH-1:0]  raddr;
    logic [KEY_WIDTH-1:0]   key_wdata;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic [KEY_WIDTH-1:0]   key_rdata;
    logic [VALUE_WIDTH-1:0] val_rdata;

    lkt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    lkt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    assign raddr = idx_reg[ADDR_WIDTH-1:0];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        vld_next     = vld_reg;
        found_next   = found_reg;
        fv_next      = fv_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        out_fv_next  = out_fv_reg;
        entries_next = entries_reg;
        we           = 1'b0;
        waddr        = count_reg[ADDR_WIDTH-1:0];
        key_wdata    = key_reg;
        val_wdata    = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    key_next   = key;
                    val_next   = value;
                    idx_next   = '0;
                    vld_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read at idx, compare the entry read last cycle (at ptr)
                if (vld_reg && key_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    fv_next    = val_rdata;
                    state_next = S_DECIDE;
                end
                else if (idx_reg < count_reg)
                begin
                    ptr_next = idx_reg[ADDR_WIDTH-1:0];
                    vld_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                out_fv_next  = '0;
                entries_next = count_reg;
                status_next  = ST_NOT_FOUND;
                done_next    = 1'b1;
                state_next   = S_IDLE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else if (count_reg == COUNT_WIDTH'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            we           = 1'b1;
                            count_next   = count_reg + 1'b1;
                            entries_next = count_reg + 1'b1;
                            status_next  = ST_OK;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (found_reg)
                        begin
                            idx_next   = COUNT_WIDTH'(ptr_reg) + 1'b1;
                            vld_next   = 1'b0;
                            done_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_OK;
                            out_fv_next = fv_reg;
                        end
                    end
                    default:
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // entry read at ptr moves down to ptr - 1
                if (vld_reg)
                begin
                    we        = 1'b1;
                    waddr     = ptr_reg - 1'b1;
                    key_wdata = key_rdata;
                    val_wdata = val_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    ptr_next = idx_reg[ADDR_WIDTH-1:0];
                    vld_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    vld_next     = 1'b0;
                    count_next   = count_reg - 1'b1;
                    entries_next = count_reg - 1'b1;
                    status_next  = ST_OK;
                    out_fv_next  = '0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            vld_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        ptr_reg     <= ptr_next;
        found_reg   <= found_next;
        fv_reg      <= fv_next;
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        out_fv_reg  <= out_fv_next;
        entries_reg <= entries_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = out_fv_reg;
    assign entries     = entries_reg;

endmodule
